// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the sorted priority queue
// Sizes, operation and status codes, and the control struct of a cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds a key and payload and, on each operation, keeps them, loads the new
// entry, or takes the entry of its upper or lower neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic                    head_cell,
    input  logic                    occupied,
    input  logic                    prev_flag,
    input  logic [KEY_BITS-1:0]     prev_key,
    input  logic [PAYLOAD_BITS-1:0] prev_payload,
    input  logic [KEY_BITS-1:0]     next_key,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    output logic                    place_flag,
    output logic [KEY_BITS-1:0]     key_out,
    output logic [PAYLOAD_BITS-1:0] payload_out,
    output logic [KEY_BITS-1:0]     key_next_out
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // The new entry belongs at or above this slot. The head slot yields only
    // to a strictly greater key; the others also yield on a tie.
    assign place_flag = !occupied
                        || (head_cell ? (key_reg < new_key) : (key_reg <= new_key));

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        priority if (ctrl.pop)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
        else if (ctrl.ins && prev_flag)
        begin
            key_next     = prev_key;
            payload_next = prev_payload;
        end
        else if (ctrl.ins && place_flag)
        begin
            key_next     = new_key;
            payload_next = new_payload;
        end
        else
        begin
            key_next     = key_reg;
            payload_next = payload_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key_out      = key_reg;
    assign payload_out  = payload_reg;
    assign key_next_out = key_next;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: max-priority queue kept in sorted order
// A row of cells holds the entries in descending key order with the head in
// the first cell; inserts and pops shift the whole row at once.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             fields
//  input    in         in_valid / in_ready   kind, key, payload
//  output   out        out_valid / out_ready popped_*, status, head_*, count
//
//  On each transfer every cell compares and shifts at once.
//  The result is held in an output register; a new item is taken in the
//  same cycle that the held result is taken, so the rate is one per cycle
//  while the output is not stalled. Reset empties the queue and drops any
//  held result. A stalled output holds in_ready low until the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    popped_valid,
    output logic [KEY_BITS-1:0]     popped_key,
    output logic [PAYLOAD_BITS-1:0] popped_payload,
    output logic [1:0]              status,
    output logic                    head_valid,
    output logic [KEY_BITS-1:0]     head_key,
    output logic [CNT_BITS-1:0]     entry_count
);

    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;
    logic                    out_valid_reg;
    logic                    popped_valid_reg;
    logic [KEY_BITS-1:0]     popped_key_reg;
    logic [PAYLOAD_BITS-1:0] popped_payload_reg;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;
    logic                    head_valid_reg;
    logic [KEY_BITS-1:0]     head_key_reg;
    logic [CNT_BITS-1:0]     entry_count_reg;

    logic       accept;
    logic       is_empty;
    logic       is_full;
    cell_ctrl_t ctrl;

    logic [DEPTH-1:0]        flag;
    logic [KEY_BITS-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
    logic [KEY_BITS-1:0]     cell_key_next [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_BITS'(DEPTH));
    assign ctrl.ins = accept && (kind == KIND_INSERT) && !is_full;
    assign ctrl.pop = accept && (kind == KIND_POP) && !is_empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    prev_flag_w;
            logic [KEY_BITS-1:0]     prev_key_w;
            logic [PAYLOAD_BITS-1:0] prev_payload_w;
            logic [KEY_BITS-1:0]     next_key_w;
            logic [PAYLOAD_BITS-1:0] next_payload_w;

            if (i == 0)
            begin : g_first
                assign prev_flag_w    = 1'b0;
                assign prev_key_w     = '0;
                assign prev_payload_w = '0;
            end
            else
            begin : g_mid
                assign prev_flag_w    = flag[i-1];
                assign prev_key_w     = cell_key[i-1];
                assign prev_payload_w = cell_payload[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_key_w     = '0;
                assign next_payload_w = '0;
            end
            else
            begin : g_inner
                assign next_key_w     = cell_key[i+1];
                assign next_payload_w = cell_payload[i+1];
            end

            spq_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .head_cell    (i == 0),
                .occupied     (CNT_BITS'(i) < count_reg),
                .prev_flag    (prev_flag_w),
                .prev_key     (prev_key_w),
                .prev_payload (prev_payload_w),
                .next_key     (next_key_w),
                .next_payload (next_payload_w),
                .new_key      (key),
                .new_payload  (payload),
                .place_flag   (flag[i]),
                .key_out      (cell_key[i]),
                .payload_out  (cell_payload[i]),
                .key_next_out (cell_key_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        priority if (ctrl.ins)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
        else if (kind == KIND_POP)
        begin
            status_next = ST_POP_EMPTY;
        end
        else
        begin
            status_next = ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_valid_reg   <= ctrl.pop;
            popped_key_reg     <= ctrl.pop ? cell_key[0] : '0;
            popped_payload_reg <= ctrl.pop ? cell_payload[0] : '0;
            status_reg         <= status_next;
            head_valid_reg     <= (count_next != '0);
            head_key_reg       <= (count_next != '0) ? cell_key_next[0] : '0;
            entry_count_reg    <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped_valid   = popped_valid_reg;
    assign popped_key     = popped_key_reg;
    assign popped_payload = popped_payload_reg;
    assign status         = status_reg;
    assign head_valid     = head_valid_reg;
    assign head_key       = head_key_reg;
    assign entry_count    = entry_count_reg;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    popped_valid,
    input logic [KEY_BITS-1:0]     popped_key,
    input logic [PAYLOAD_BITS-1:0] popped_payload,
    input logic [1:0]              status,
    input logic                    head_valid,
    input logic [KEY_BITS-1:0]     head_key,
    input logic [CNT_BITS-1:0]     entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_key)
            && $stable(popped_valid) && $stable(popped_payload)
            && $stable(head_valid)
            && $stable(status) && $stable(entry_count) && $stable(head_key))
        else $error("Stalled result changed before its transfer.");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> head_valid == (entry_count != '0))
        else $error("Head valid disagrees with the entry count.");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_POP_EMPTY |-> !popped_valid && entry_count == '0)
        else $error("Pop on empty queue reported an entry or a count.");

    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && popped_valid |-> status == ST_OK
            && entry_count != CNT_BITS'(DEPTH))
        else $error("Popped entry with an error status or a full count.");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == CNT_BITS'(DEPTH)
            && !popped_valid)
        else $error("Rejected insert while the queue was not full.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
